// ----- hdl/sle_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list engine package
// Shared widths, operation and status codes, the controller/datapath
// command and status groups, and the signed key ordering function.
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int KEY_W     = 32;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int COUNT_O_W = 5;

    // Operation codes carried in the mode field.
    localparam logic [MODE_W-1:0] MODE_INSERT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CONTAINS = 2'd2;
    localparam logic [MODE_W-1:0] MODE_POP      = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the incoming item
        logic compare;  // register the per-cell compare flags
        logic update;   // shift the cells and load the result register
    } sle_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_busy; // result register holds an item that is not yet taken
    } sle_stat_t;

    // Signed order on raw key patterns: true when a < b.
    function automatic logic key_less(input logic [KEY_W-1:0] a,
                                      input logic [KEY_W-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

endpackage

// ----- hdl/sle_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list engine controller
// Sequences each item through capture, compare and update, and holds off
// the update while the result register is still occupied.
// ----------------------------------------------------------------------------
module sle_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  sle_pkg::sle_stat_t  stat,
    output sle_pkg::sle_cmd_t   cmd
);
    import sle_pkg::*;

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_COMPARE = 2'd1;
    localparam logic [1:0] S_UPDATE  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and command decode.
    always_comb
    begin
        state_next  = state_reg;
        cmd.load    = 1'b0;
        cmd.compare = 1'b0;
        cmd.update  = 1'b0;
        in_stall    = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_COMPARE;
                end
            end
            S_COMPARE:
            begin
                cmd.compare = 1'b1;
                state_next  = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.update = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // An accepted item always moves on to the compare step.
    a_load_to_compare: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_COMPARE))
        else $error("accepted item did not reach compare");

    // No item is taken while one is still in flight.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input accepted while busy");

    // The update never overwrites a result that is still waiting.
    a_update_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> !stat.out_busy)
        else $error("update while result register busy");

endmodule

// ----- hdl/sle_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list engine datapath
// A row of key cells, each comparing against the request key and shifting
// to its neighbor, plus the entry count and the result register.
// ----------------------------------------------------------------------------
module sle_datapath
#(
    parameter int CAPACITY = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  sle_pkg::sle_cmd_t             cmd,
    output sle_pkg::sle_stat_t            stat,
    input  logic [sle_pkg::MODE_W-1:0]    mode,
    input  logic signed [sle_pkg::KEY_W-1:0] key,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sle_pkg::STATUS_W-1:0]  status,
    output logic                          found,
    output logic [sle_pkg::COUNT_O_W-1:0] entry_count,
    output logic signed [sle_pkg::KEY_W-1:0] smallest_key
);
    import sle_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Request captured at acceptance.
    logic [MODE_W-1:0]   mode_reg;
    logic [KEY_W-1:0]    key_reg;

    // Cell row and entry count.
    logic [KEY_W-1:0]    cell_reg  [CAPACITY];
    logic [KEY_W-1:0]    cell_next [CAPACITY];
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    // Per-cell compare flags, registered in the compare step.
    logic [CAPACITY-1:0] ins_sh;      // cell is at or past the insert point
    logic [CAPACITY-1:0] rem_sh;      // cell is at or past the first key >= request
    logic [CAPACITY-1:0] eq_vec;
    logic [CAPACITY-1:0] ins_sh_reg;
    logic [CAPACITY-1:0] rem_sh_reg;
    logic                found_reg;

    // Result register.
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                found_out_reg;
    logic [CNT_W-1:0]    count_out_reg;
    logic [KEY_W-1:0]    smallest_reg;
    logic [CNT_W+COUNT_O_W-1:0] count_ext;

    // Update decode.
    logic                is_full;
    logic                is_empty;
    logic                do_insert;
    logic                do_shift_left;
    logic [STATUS_W-1:0] status_next;
    logic [CAPACITY-1:0] left_sh;

    // Capture the request.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            key_reg  <= key;
        end
    end

    // Each cell compares its own key against the request key.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cmp
        localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
        logic held;
        assign held      = IDX < count_reg;
        assign ins_sh[i] = !held || key_less(key_reg, cell_reg[i]);
        assign rem_sh[i] = held && !key_less(cell_reg[i], key_reg);
        assign eq_vec[i] = held && (cell_reg[i] == key_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.compare)
        begin
            ins_sh_reg <= ins_sh;
            rem_sh_reg <= rem_sh;
            found_reg  <= |eq_vec;
        end
    end

    // Operation outcome and count update.
    always_comb
    begin
        is_full       = (count_reg == CNT_W'(CAPACITY));
        is_empty      = (count_reg == '0);
        do_insert     = 1'b0;
        do_shift_left = 1'b0;
        count_next    = count_reg;
        status_next   = ST_OK;
        case (mode_reg)
            MODE_INSERT:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    do_insert  = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            MODE_REMOVE:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (!found_reg)
                begin
                    status_next = ST_NOT_FOUND;
                end
                else
                begin
                    do_shift_left = 1'b1;
                    count_next    = count_reg - 1'b1;
                end
            end
            MODE_CONTAINS:
            begin
                status_next = found_reg ? ST_OK : ST_NOT_FOUND;
            end
            default:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    do_shift_left = 1'b1;
                    count_next    = count_reg - 1'b1;
                end
            end
        endcase
    end

    // Pop shifts the whole row; remove shifts from the first matching cell on.
    assign left_sh = (mode_reg == MODE_POP) ? '1 : rem_sh_reg;

    // Next value of each cell from its own flags and its two neighbors.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [KEY_W-1:0] from_left;
        logic [KEY_W-1:0] from_right;
        logic             left_moves;
        if (i == 0)
        begin : g_first
            assign from_left  = cell_reg[i];
            assign left_moves = 1'b0;
        end
        else
        begin : g_mid
            assign from_left  = cell_reg[i-1];
            assign left_moves = ins_sh_reg[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign from_right = cell_reg[i];
        end
        else
        begin : g_inner
            assign from_right = cell_reg[i+1];
        end

        always_comb
        begin
            cell_next[i] = cell_reg[i];
            if (do_insert)
            begin
                if (left_moves)
                begin
                    cell_next[i] = from_left;
                end
                else if (ins_sh_reg[i])
                begin
                    cell_next[i] = key_reg;
                end
            end
            else if (do_shift_left && left_sh[i])
            begin
                cell_next[i] = from_right;
            end
        end

        always_ff @(posedge clk)
        begin
            if (cmd.update)
            begin
                cell_reg[i] <= cell_next[i];
            end
        end
    end

    // Entry count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.update)
        begin
            count_reg <= count_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            status_reg    <= status_next;
            found_out_reg <= (mode_reg == MODE_POP) ? 1'b0 : found_reg;
            count_out_reg <= count_next;
            smallest_reg  <= (count_next == '0) ? '0 : cell_next[0];
        end
    end

    assign count_ext     = {{COUNT_O_W{1'b0}}, count_out_reg};
    assign stat.out_busy = out_valid_reg && out_stall;
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign found         = found_out_reg;
    assign entry_count   = count_ext[COUNT_O_W-1:0];
    assign smallest_key  = smallest_reg;

    // The count never passes the capacity.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // The count moves only on an update.
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.update |=> $stable(count_reg))
        else $error("entry count changed outside update");

    // A full list refuses an insert and keeps its count.
    a_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && mode_reg == MODE_INSERT && is_full) |=>
            (status_reg == ST_FULL) && $stable(count_reg))
        else $error("insert into full list not refused");

    // Every update produces a waiting result.
    a_update_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> out_valid_reg)
        else $error("update did not present a result");

endmodule

// ----- hdl/sorted_list_engine_unit.sv -----
`timescale 1ns / 1ps
// Each item is captured, compared across the cell row, then shifts the
// cell row, and its result is registered on that update; the update waits
// while the result stays stalled, and no new item is taken until it is done.
// The next item may be accepted while an earlier result still waits.
// Reset clears the entry count and the result valid flag; key cells are
// left unwritten and are never read before they hold a key.
// ----------------------------------------------------------------------------
// Sorted list engine top level
// Holds up to CAPACITY signed keys in ascending order and serves insert,
// remove, contains and pop requests, one result per item.
// ----------------------------------------------------------------------------
module sorted_list_engine_unit
#(
    parameter int CAPACITY = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [sle_pkg::MODE_W-1:0]    mode,
    input  logic signed [sle_pkg::KEY_W-1:0] key,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sle_pkg::STATUS_W-1:0]  status,
    output logic                          found,
    output logic [sle_pkg::COUNT_O_W-1:0] entry_count,
    output logic signed [sle_pkg::KEY_W-1:0] smallest_key
);
    import sle_pkg::*;

    sle_cmd_t  cmd;
    sle_stat_t stat;

    // Sequencing.
    sle_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Cell row, count and result register.
    sle_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .mode         (mode),
        .key          (key),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .found        (found),
        .entry_count  (entry_count),
        .smallest_key (smallest_key)
    );

endmodule

// ----- bench/sorted_list_engine_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list engine unit testbench
// Drives insert, remove, contains and pop requests through the valid/stall
// handshake with random gaps and stalls, predicts each result from a sorted
// key list kept in the bench, and checks every result field by field.
// ----------------------------------------------------------------------------
module sorted_list_engine_unit_test;

    import sle_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int RANDOM_REQS = 400;
    localparam int DUE_DEPTH   = 1024;
    localparam int CYCLE_LIMIT = 200000;

    // Keys that recur often so that duplicates, hits and extremes show up.
    localparam logic [KEY_W-1:0] KEY_POOL [8] = '{
        32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
        32'h0000_0001, 32'h0000_0002, 32'hFFFF_FFFE, 32'h0000_0064
    };

    // One request waiting to be driven; drain holds it until all results are in.
    typedef struct {
        logic [MODE_W-1:0] op;
        logic [KEY_W-1:0]  k;
        bit                drain;
    } request_t;

    // One predicted result.
    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic                 found;
        logic [COUNT_O_W-1:0] entries;
        logic [KEY_W-1:0]     smallest;
    } result_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [MODE_W-1:0]           mode = MODE_INSERT;
    logic signed [KEY_W-1:0]     key = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [STATUS_W-1:0]         status;
    logic                        found;
    logic [COUNT_O_W-1:0]        entry_count;
    logic signed [KEY_W-1:0]     smallest_key;

    request_t                    pending_requests[$];
    logic signed [KEY_W-1:0]     held_keys[$];
    result_t                     due_results [0:DUE_DEPTH-1];
    int                          n_sent = 0;
    int                          n_checked = 0;
    int                          total_requests = 0;
    int                          gap_left = 0;
    int                          stall_left = 0;
    int                          error_count = 0;
    int                          cycle_count = 0;

    sorted_list_engine_unit #(
        .CAPACITY     (CAPACITY)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .key          (key),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .found        (found),
        .entry_count  (entry_count),
        .smallest_key (smallest_key)
    );

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one request to the bench copy of the list and returns its result.
    function automatic result_t apply_request(input logic [MODE_W-1:0] op,
                                              input logic [KEY_W-1:0] k);
        result_t                 r;
        int                      hit;
        int                      pos;
        logic signed [KEY_W-1:0] sk;
        sk       = $signed(k);
        hit      = -1;
        r.status = ST_OK;
        r.found  = 1'b0;
        if (op != MODE_POP)
        begin
            for (int i = 0; i < held_keys.size(); i++)
            begin
                if (hit < 0 && held_keys[i] == sk)
                    hit = i;
            end
            r.found = (hit >= 0);
        end
        case (op)
            MODE_INSERT:
            begin
                if (held_keys.size() >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    // Equal keys stay ahead of the new one.
                    pos = 0;
                    while (pos < held_keys.size() && !(sk < held_keys[pos]))
                        pos++;
                    held_keys.insert(pos, sk);
                end
            end
            MODE_REMOVE:
            begin
                if (held_keys.size() == 0)
                    r.status = ST_EMPTY;
                else if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else
                    held_keys.delete(hit);
            end
            MODE_CONTAINS:
            begin
                r.status = (hit >= 0) ? ST_OK : ST_NOT_FOUND;
            end
            default:
            begin
                if (held_keys.size() == 0)
                    r.status = ST_EMPTY;
                else
                    void'(held_keys.pop_front());
            end
        endcase
        r.entries  = COUNT_O_W'(held_keys.size());
        r.smallest = (held_keys.size() > 0) ? held_keys[0] : '0;
        return r;
    endfunction

    function automatic void push_request(input logic [MODE_W-1:0] op,
                                         input logic [KEY_W-1:0] k,
                                         input bit drain);
        request_t q;
        q.op    = op;
        q.k     = k;
        q.drain = drain;
        pending_requests.push_back(q);
    endfunction

    // Driver: predicts each accepted item and presents the next one after its gap.
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        request_t                q;
        logic                    v_next;
        int                      g_next;
        int                      s_next;
        logic [MODE_W-1:0]       m_next;
        logic [KEY_W-1:0]        k_next;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            mode     <= MODE_INSERT;
            key      <= '0;
            gap_left <= 0;
            n_sent   <= 0;
        end
        else
        begin
            v_next = in_valid;
            g_next = gap_left;
            s_next = n_sent;
            m_next = mode;
            k_next = key;
            if (in_valid && !in_stall)
            begin
                due_results[n_sent] <= apply_request(mode, key);
                s_next = n_sent + 1;
                v_next = 1'b0;
                // Every fourth stretch of 50 items goes without gaps.
                g_next = (((s_next / 50) % 4) == 2) ? 0 : $urandom_range(0, 19);
            end
            else if (!in_valid && g_next > 0)
                g_next = g_next - 1;
            if (!v_next && g_next == 0 && pending_requests.size() > 0 &&
                (!pending_requests[0].drain || s_next == n_checked))
            begin
                q      = pending_requests.pop_front();
                m_next = q.op;
                k_next = q.k;
                v_next = 1'b1;
            end
            in_valid <= v_next;
            mode     <= m_next;
            key      <= k_next;
            gap_left <= g_next;
            n_sent   <= s_next;
        end
    end

    // Monitor: takes results under random stalls and checks them in order.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        result_t want;
        int      stall_next;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
            n_checked  <= 0;
        end
        else
        begin
            stall_next = stall_left;
            if (out_valid && !out_stall)
            begin
                if (n_checked >= n_sent)
                begin
                    $error("result with no item waiting: status %0d", status);
                    error_count++;
                end
                else
                begin
                    want = due_results[n_checked];
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        error_count++;
                    end
                    if (found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, found);
                        error_count++;
                    end
                    if (entry_count !== want.entries)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entries, entry_count);
                        error_count++;
                    end
                    if (smallest_key !== want.smallest)
                    begin
                        $error("smallest_key: expected %0d, got %0d",
                               $signed(want.smallest), smallest_key);
                        error_count++;
                    end
                    n_checked <= n_checked + 1;
                end
                // Every fourth stretch of 60 results is taken without stalls.
                stall_next = (((n_checked / 60) % 4) == 1) ? 0 : $urandom_range(0, 19);
            end
            else if (stall_next > 0)
                stall_next = stall_next - 1;
            out_stall  <= (stall_next > 0);
            stall_left <= stall_next;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sorted_list_engine_unit_test: done, errors");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int                n;
        int                pick;
        bit                fill_phase;
        logic [MODE_W-1:0] op;
        logic [KEY_W-1:0]  k;

        // Requests on an empty list.
        push_request(MODE_POP, 32'h0000_0000, 1'b0);
        push_request(MODE_REMOVE, 32'h0000_0005, 1'b0);
        push_request(MODE_CONTAINS, 32'h0000_0000, 1'b0);
        // Extremes, a duplicate and ordering across the sign boundary.
        push_request(MODE_INSERT, 32'h7FFF_FFFF, 1'b0);
        push_request(MODE_INSERT, 32'h8000_0000, 1'b0);
        push_request(MODE_INSERT, 32'h0000_0000, 1'b0);
        push_request(MODE_INSERT, 32'hFFFF_FFFF, 1'b0);
        push_request(MODE_INSERT, 32'h0000_0000, 1'b0);
        push_request(MODE_INSERT, 32'h0000_0001, 1'b0);
        push_request(MODE_CONTAINS, 32'h0000_0000, 1'b0);
        push_request(MODE_CONTAINS, 32'h0000_0002, 1'b0);
        push_request(MODE_REMOVE, 32'h0000_0000, 1'b0);
        push_request(MODE_REMOVE, 32'h0000_0007, 1'b0);
        push_request(MODE_POP, 32'hFFFF_FFFF, 1'b0);
        // Fill the list, then insert a held key into the full list.
        for (n = 0; n < 12; n++)
            push_request(MODE_INSERT, 32'(n * 7 - 40), 1'b0);
        push_request(MODE_INSERT, 32'h7FFF_FFFF, 1'b0);

        // Random part: alternating fill and drain phases sweep the list
        // between empty and full; keys mix a small pool with full-range values.
        for (n = 0; n < RANDOM_REQS; n++)
        begin
            fill_phase = ((n / 40) % 2) == 0;
            pick = $urandom_range(0, 99);
            if (fill_phase)
                op = (pick < 65) ? MODE_INSERT : (pick < 80) ? MODE_CONTAINS :
                     (pick < 90) ? MODE_REMOVE : MODE_POP;
            else
                op = (pick < 15) ? MODE_INSERT : (pick < 30) ? MODE_CONTAINS :
                     (pick < 65) ? MODE_REMOVE : MODE_POP;
            pick = $urandom_range(0, 99);
            if (pick < 60)
                k = KEY_POOL[$urandom_range(0, 7)];
            else if (pick < 70)
                k = 32'($urandom_range(0, 15)) - 32'd8;
            else
                k = $urandom();
            push_request(op, k, (n == 0) || (n == RANDOM_REQS / 2));
        end
        total_requests = pending_requests.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (n_sent != total_requests)
            @(posedge clk);
        while (n_checked != n_sent)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (error_count == 0)
            $display("sorted_list_engine_unit_test: done, clean");
        else
            $display("sorted_list_engine_unit_test: done, errors");
        $finish;
    end

endmodule
